### hdl/palru_pkg.sv
`default_nettype none
package palru_pkg;

   localparam int FRAME_COUNT = 16;
   localparam int FRAME_W = 4;
   localparam int PAGE_UNITS = 4;
   localparam int OFF_W = 2;
   localparam int PROC_SLOTS = 16;
   localparam int SLOT_W = 4;
   localparam int PAGES_PER_PROC = 16;
   localparam int PAGE_W = 4;
   localparam int PT_DEPTH = PROC_SLOTS * PAGES_PER_PROC;
   localparam int PT_AW = SLOT_W + PAGE_W;
   localparam int CNT_W = 32;

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_XLATE = 2'd2;

   typedef struct packed {
      logic [1:0] cmd;
      logic [3:0] proc_id;
      logic [6:0] alloc_size;
      logic [7:0] logical_addr;
   } req_type;

   typedef struct packed {
      logic [5:0]       phys_addr;
      logic             fault;
      logic [4:0]       evicted_now;
      logic [CNT_W-1:0] alloc_total;
      logic [CNT_W-1:0] fault_total;
      logic [CNT_W-1:0] evict_total;
      logic [CNT_W-1:0] frag_total;
   } rsp_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic [CNT_W-1:0]   last;
   } pt_entry_type;

   typedef struct packed {
      logic load;
      logic alloc_end;
      logic scan_read;
      logic scan_cmp;
      logic evict;
      logic map;
      logic free_read;
      logic free_upd;
      logic tr_read;
      logic tr_upd;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       pages_done;
      logic       free_avail;
      logic       scan_last;
      logic       page_last;
      logic       tr_hit;
      logic       rsp_hold;
   } dp_status_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a);
      return (&a) ? a : a + CNT_W'(1);
   endfunction

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
   endfunction

endpackage
`default_nettype wire

### hdl/paged_allocator_lru_translate_top.sv
`default_nettype none
// Paged allocator with LRU frame replacement, one command at a time. An allocate
// maps each page to a free frame when one is free, and otherwise runs an LRU
// victim search for that page, which reads the page table RAM once per frame over
// its single read port. The result sits in an output register, so the next
// command can be taken while the previous result waits for rsp_ready.
module paged_allocator_lru_translate_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire palru_pkg::req_type req,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output palru_pkg::rsp_type      rsp
);

   palru_pkg::dp_cmd_type    dp_cmd;
   palru_pkg::dp_status_type dp_st;

   palru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (dp_st),
      .cmd       (dp_cmd)
   );

   palru_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (dp_cmd),
      .st        (dp_st),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in progress");

   a_fault_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.fault |-> rsp.phys_addr == '0 && rsp.evicted_now == '0)
      else $error("faulting result carries an address or evictions");

   a_finish_when_free: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.finish |-> !(rsp_valid && !rsp_ready))
      else $error("result register overwritten before transfer");

endmodule
`default_nettype wire

### hdl/palru_ram.sv
`default_nettype none
module palru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

### hdl/palru_ctrl.sv
`default_nettype none
module palru_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire palru_pkg::dp_status_type st,
   output palru_pkg::dp_cmd_type        cmd
);

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_DISPATCH   = 4'd1;
   localparam logic [3:0] S_ALLOC_PAGE = 4'd2;
   localparam logic [3:0] S_SCAN_RD    = 4'd3;
   localparam logic [3:0] S_SCAN_CMP   = 4'd4;
   localparam logic [3:0] S_EVICT      = 4'd5;
   localparam logic [3:0] S_MAP        = 4'd6;
   localparam logic [3:0] S_FREE_RD    = 4'd7;
   localparam logic [3:0] S_FREE_UPD   = 4'd8;
   localparam logic [3:0] S_TR_RD      = 4'd9;
   localparam logic [3:0] S_TR_UPD     = 4'd10;
   localparam logic [3:0] S_FINISH     = 4'd11;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (st.cmd)
               palru_pkg::CMD_ALLOC: state_in = S_ALLOC_PAGE;
               palru_pkg::CMD_FREE:  state_in = S_FREE_RD;
               palru_pkg::CMD_XLATE: state_in = S_TR_RD;
               default:              state_in = S_FINISH;
            endcase
         end
         S_ALLOC_PAGE: begin
            priority if (st.pages_done) begin
               cmd.alloc_end = 1'b1;
               state_in = S_FINISH;
            end else if (st.free_avail) begin
               state_in = S_MAP;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            cmd.scan_read = 1'b1;
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            cmd.scan_cmp = 1'b1;
            state_in = st.scan_last ? S_EVICT : S_SCAN_RD;
         end
         S_EVICT: begin
            cmd.evict = 1'b1;
            state_in = S_MAP;
         end
         S_MAP: begin
            cmd.map = 1'b1;
            state_in = S_ALLOC_PAGE;
         end
         S_FREE_RD: begin
            cmd.free_read = 1'b1;
            state_in = S_FREE_UPD;
         end
         S_FREE_UPD: begin
            cmd.free_upd = 1'b1;
            state_in = st.page_last ? S_FINISH : S_FREE_RD;
         end
         S_TR_RD: begin
            cmd.tr_read = 1'b1;
            state_in = st.tr_hit ? S_TR_UPD : S_FINISH;
         end
         S_TR_UPD: begin
            cmd.tr_upd = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!st.rsp_hold) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

### hdl/palru_datapath.sv
`default_nettype none
module palru_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire palru_pkg::req_type    req,
   input  wire palru_pkg::dp_cmd_type cmd,
   output palru_pkg::dp_status_type   st,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output palru_pkg::rsp_type         rsp
);

   localparam int FW = palru_pkg::FRAME_W;
   localparam int PW = palru_pkg::PAGE_W;
   localparam int SW = palru_pkg::SLOT_W;
   localparam int AW = palru_pkg::PT_AW;
   localparam int CW = palru_pkg::CNT_W;
   localparam int EW = $bits(palru_pkg::pt_entry_type);

   palru_pkg::req_type req_ff;
   logic [PW:0]   pages_ff, pg_ff;
   logic [FW-1:0] scan_f_ff, best_ff;
   logic [CW-1:0] best_age_ff;
   logic          best_maps_ff;
   logic [AW-1:0] best_addr_ff;
   logic          use_victim_ff;
   logic [4:0]    evicted_ff;
   logic [5:0]    phys_ff;
   logic          fault_ff;
   logic [CW-1:0] clock_ff, alloc_cnt_ff, fault_cnt_ff, evict_cnt_ff, frag_ff;
   logic [palru_pkg::FRAME_COUNT-1:0] busy_ff;
   logic [SW-1:0] owner_slot_ff [palru_pkg::FRAME_COUNT];
   logic [PW-1:0] owner_page_ff [palru_pkg::FRAME_COUNT];
   logic [palru_pkg::PT_DEPTH-1:0] valid_ff;
   logic          rsp_valid_ff;
   palru_pkg::rsp_type rsp_ff;

   palru_pkg::pt_entry_type rd_entry, wr_entry;
   logic [EW-1:0] rd_raw;
   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;

   logic [SW-1:0] slot;
   logic [PW-1:0] xl_page;
   logic          xl_range_bad;
   logic [AW-1:0] cur_addr, xl_addr, owner_addr;
   logic [FW-1:0] free_idx, map_frame;
   logic          maps_back;
   logic [CW-1:0] age;
   logic [PW:0]   pages_calc;
   logic [6:0]    used_units;
   logic [7:0]    size_round;

   assign slot = req_ff.proc_id[SW-1:0];
   assign xl_page = req_ff.logical_addr[palru_pkg::OFF_W +: PW];
   assign xl_range_bad = |req_ff.logical_addr[7:palru_pkg::OFF_W+PW];
   assign cur_addr = {slot, pg_ff[PW-1:0]};
   assign xl_addr = {slot, xl_page};
   assign owner_addr = {owner_slot_ff[scan_f_ff], owner_page_ff[scan_f_ff]};

   always_comb begin
      free_idx = '0;
      for (int i = palru_pkg::FRAME_COUNT - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_idx = FW'(i);
         end
      end
   end

   assign map_frame = use_victim_ff ? best_ff : free_idx;
   assign rd_entry = palru_pkg::pt_entry_type'(rd_raw);
   assign maps_back = valid_ff[owner_addr] && (rd_entry.frame == scan_f_ff);
   assign age = maps_back ? rd_entry.last : '0;

   // Page count rounds up and saturates at the per-process limit.
   assign size_round = {1'b0, req.alloc_size} + 8'(palru_pkg::PAGE_UNITS - 1);
   assign pages_calc = (size_round[7:palru_pkg::OFF_W] > 6'(palru_pkg::PAGES_PER_PROC))
                       ? (PW+1)'(palru_pkg::PAGES_PER_PROC)
                       : (PW+1)'(size_round[7:palru_pkg::OFF_W]);
   assign used_units = {pages_ff, {palru_pkg::OFF_W{1'b0}}};

   always_comb begin
      ram_re = cmd.scan_read || cmd.free_read || cmd.tr_read;
      ram_raddr = cur_addr;
      if (cmd.scan_read) begin
         ram_raddr = owner_addr;
      end else if (cmd.tr_read) begin
         ram_raddr = xl_addr;
      end
      ram_we = cmd.map || cmd.tr_upd;
      ram_waddr = cmd.map ? cur_addr : xl_addr;
      wr_entry.frame = cmd.map ? map_frame : rd_entry.frame;
      wr_entry.last = clock_ff;
   end

   palru_ram #(
      .WIDTH (EW),
      .DEPTH (palru_pkg::PT_DEPTH)
   ) u_pt_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (wr_entry),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (rd_raw)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
         valid_ff <= '0;
         clock_ff <= '0;
         alloc_cnt_ff <= '0;
         fault_cnt_ff <= '0;
         evict_cnt_ff <= '0;
         frag_ff <= '0;
         rsp_valid_ff <= 1'b0;
         scan_f_ff <= '0;
         use_victim_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            req_ff <= req;
            pg_ff <= '0;
            evicted_ff <= '0;
            phys_ff <= '0;
            fault_ff <= 1'b0;
            pages_ff <= pages_calc;
            if (req.cmd == palru_pkg::CMD_ALLOC) begin
               valid_ff[{req.proc_id[SW-1:0], {PW{1'b0}}} +: palru_pkg::PAGES_PER_PROC]
                  <= '0;
               alloc_cnt_ff <= palru_pkg::sat_inc(alloc_cnt_ff);
            end
            if (req.cmd == palru_pkg::CMD_ALLOC || req.cmd == palru_pkg::CMD_FREE) begin
               clock_ff <= palru_pkg::sat_inc(clock_ff);
            end
         end
         if (cmd.alloc_end && ({1'b0, used_units} > {1'b0, req_ff.alloc_size})) begin
            frag_ff <= palru_pkg::sat_add(frag_ff, CW'(used_units - req_ff.alloc_size));
         end
         if (cmd.scan_cmp) begin
            if (scan_f_ff == '0 || age < best_age_ff) begin
               best_ff <= scan_f_ff;
               best_age_ff <= age;
               best_maps_ff <= maps_back;
               best_addr_ff <= owner_addr;
            end
            scan_f_ff <= scan_f_ff + FW'(1);
         end
         if (cmd.evict) begin
            if (best_maps_ff) begin
               valid_ff[best_addr_ff] <= 1'b0;
            end
            busy_ff[best_ff] <= 1'b0;
            fault_cnt_ff <= palru_pkg::sat_inc(fault_cnt_ff);
            evict_cnt_ff <= palru_pkg::sat_inc(evict_cnt_ff);
            evicted_ff <= evicted_ff + 5'd1;
            use_victim_ff <= 1'b1;
         end
         if (cmd.map) begin
            valid_ff[cur_addr] <= 1'b1;
            busy_ff[map_frame] <= 1'b1;
            owner_slot_ff[map_frame] <= slot;
            owner_page_ff[map_frame] <= pg_ff[PW-1:0];
            use_victim_ff <= 1'b0;
            pg_ff <= pg_ff + (PW+1)'(1);
         end
         if (cmd.free_upd) begin
            if (valid_ff[cur_addr]) begin
               busy_ff[rd_entry.frame] <= 1'b0;
               valid_ff[cur_addr] <= 1'b0;
            end
            pg_ff <= pg_ff + (PW+1)'(1);
         end
         if (cmd.tr_read && !st.tr_hit) begin
            fault_ff <= 1'b1;
            fault_cnt_ff <= palru_pkg::sat_inc(fault_cnt_ff);
         end
         if (cmd.tr_upd) begin
            phys_ff <= 6'({rd_entry.frame, req_ff.logical_addr[palru_pkg::OFF_W-1:0]});
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.phys_addr <= phys_ff;
         rsp_ff.fault <= fault_ff;
         rsp_ff.evicted_now <= evicted_ff;
         rsp_ff.alloc_total <= alloc_cnt_ff;
         rsp_ff.fault_total <= fault_cnt_ff;
         rsp_ff.evict_total <= evict_cnt_ff;
         rsp_ff.frag_total <= frag_ff;
      end
   end

   always_comb begin
      st.cmd = req_ff.cmd;
      st.pages_done = (pg_ff == pages_ff);
      st.free_avail = ~&busy_ff;
      st.scan_last = (scan_f_ff == FW'(palru_pkg::FRAME_COUNT - 1));
      st.page_last = (pg_ff[PW-1:0] == PW'(palru_pkg::PAGES_PER_PROC - 1));
      st.tr_hit = !xl_range_bad && valid_ff[xl_addr];
      st.rsp_hold = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

endmodule
`default_nettype wire
